FILE: rtl/core/lossy_delay_datagram_scheduler_assert.svh
// Assertion helpers, clocked on clk, disabled during rst.
`ifndef LOSSY_DELAY_DATAGRAM_SCHEDULER_ASSERT_SVH
`define LOSSY_DELAY_DATAGRAM_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define LDDS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ldds assertion failed");

// next-cycle implication
`define LDDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ldds assertion failed");

`endif

FILE: rtl/core/ldds_pkg.sv
package ldds_pkg;

  localparam int NUM_SOCKETS_DEF = 16;
  localparam int INBOX_DEPTH_DEF = 64;

  localparam logic [15:0] FIRST_FREE_PORT_RST = 16'd49152;

  typedef enum logic [1:0] {
    OP_BIND = 2'd0,
    OP_SEND = 2'd1,
    OP_TAKE = 2'd2,
    OP_PEEK = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_LOSS   = 2'd0,
    REG_LAT    = 2'd1,
    REG_JITTER = 2'd2,
    REG_PORT   = 2'd3
  } reg_idx_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNAVAIL = 3'd1;
  localparam logic [2:0] ST_BUSY    = 3'd2;
  localparam logic [2:0] ST_DROPPED = 3'd3;
  localparam logic [2:0] ST_NONE    = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  // endpoint lookup token
  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    logic [15:0] port;
    logic [3:0]  sock;
    logic        found;
    logic        bound;
  } sock_pkt_t;

  // inbox search token
  typedef struct packed {
    logic        valid;
    logic [3:0]  key;
    logic        found;
    logic [62:0] due;
    logic [31:0] seq;
    logic [47:0] sender;
    logic [15:0] tag;
    logic        free_found;
  } inbox_pkt_t;

endpackage

FILE: rtl/core/ldds_sock_cell.sv
module ldds_sock_cell #(
  parameter int NUM_SOCKETS = 16,
  parameter int IDX = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ldds_pkg::sock_pkt_t              pin,
  input  logic [$clog2(NUM_SOCKETS)-1:0]   oin,
  output ldds_pkg::sock_pkt_t              pout,
  output logic [$clog2(NUM_SOCKETS)-1:0]   oout,
  input  logic                             we,
  input  logic [3:0]                       wr_sock,
  input  logic [31:0]                      wr_addr,
  input  logic [15:0]                      wr_port
);
  import ldds_pkg::*;

  localparam int SW = $clog2(NUM_SOCKETS);

  logic        flag;
  logic [31:0] addr;
  logic [15:0] port;
  logic        hit;
  logic        mine;

  assign mine = (int'(wr_sock) == IDX);
  assign hit  = flag && (addr == pin.addr) && (port == pin.port) && !pin.found;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (we && mine) begin
      flag <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we && mine) begin
      addr <= wr_addr;
      port <= wr_port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pout.valid <= 1'b0;
    end else begin
      pout.valid <= pin.valid;
    end
    pout.addr  <= pin.addr;
    pout.port  <= pin.port;
    pout.sock  <= pin.sock;
    pout.found <= pin.found || hit;
    pout.bound <= (int'(pin.sock) == IDX) ? flag : pin.bound;
    oout       <= hit ? SW'(IDX) : oin;
  end

endmodule

FILE: rtl/core/ldds_inbox_cell.sv
module ldds_inbox_cell #(
  parameter int NUM_SOCKETS = 16,
  parameter int INBOX_DEPTH = 64,
  parameter int IDX = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ldds_pkg::inbox_pkt_t             pin,
  input  logic [$clog2(INBOX_DEPTH)-1:0]   bin,
  input  logic [$clog2(INBOX_DEPTH)-1:0]   fin,
  output ldds_pkg::inbox_pkt_t             pout,
  output logic [$clog2(INBOX_DEPTH)-1:0]   bout,
  output logic [$clog2(INBOX_DEPTH)-1:0]   fout,
  input  logic                             we,
  input  logic                             clr,
  input  logic [$clog2(INBOX_DEPTH)-1:0]   wr_idx,
  input  logic [$clog2(NUM_SOCKETS)-1:0]   wr_owner,
  input  logic [62:0]                      wr_due,
  input  logic [31:0]                      wr_seq,
  input  logic [47:0]                      wr_sender,
  input  logic [15:0]                      wr_tag
);
  import ldds_pkg::*;

  localparam int IW = $clog2(INBOX_DEPTH);
  localparam int SW = $clog2(NUM_SOCKETS);
  localparam int KW = (SW > 4) ? SW : 4;

  logic          vld;
  logic [SW-1:0] owner;
  logic [62:0]   due;
  logic [31:0]   seq;
  logic [47:0]   sender;
  logic [15:0]   tag;
  logic          mine;
  logic          better;
  logic          take_free;

  assign mine = (wr_idx == IW'(IDX));
  assign better = vld && (KW'(owner) == KW'(pin.key)) &&
                  (!pin.found || (due < pin.due) || ((due == pin.due) && (seq < pin.seq)));
  assign take_free = !vld && !pin.free_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (we && mine) begin
      vld <= 1'b1;
    end else if (clr && mine) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we && mine) begin
      owner  <= wr_owner;
      due    <= wr_due;
      seq    <= wr_seq;
      sender <= wr_sender;
      tag    <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pout.valid <= 1'b0;
    end else begin
      pout.valid <= pin.valid;
    end
    pout.key        <= pin.key;
    pout.found      <= pin.found || better;
    pout.due        <= better ? due : pin.due;
    pout.seq        <= better ? seq : pin.seq;
    pout.sender     <= better ? sender : pin.sender;
    pout.tag        <= better ? tag : pin.tag;
    pout.free_found <= pin.free_found || take_free;
    bout            <= better ? IW'(IDX) : bin;
    fout            <= take_free ? IW'(IDX) : fin;
  end

endmodule

FILE: rtl/core/lossy_delay_datagram_scheduler.sv
// channel  | handshake            | payload
// in       | in_valid / in_stall  | op socket local_addr local_port dest_addr dest_port
//          |                      | payload_tag now_ns loss_draw jitter_draw
// out      | out_valid / out_stall| status time_ns from_addr from_port out_tag seq_number
// cfg      | cfg_we               | cfg_index cfg_data
// One transaction at a time; the result waits for the token to pass both the socket
// and the inbox cell chains (one cell per cycle).
// A new transaction is accepted while the previous result waits in the output register.
// Sync reset clears bindings, inbox valid bits, sequence, registers (auto port 49152);
// no clearing pass. in_stall is high during reset.
// out_stall holds the result and blocks only the commit of the next transaction.
module lossy_delay_datagram_scheduler #(
  parameter int NUM_SOCKETS = ldds_pkg::NUM_SOCKETS_DEF,
  parameter int INBOX_DEPTH = ldds_pkg::INBOX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [3:0]  socket,
  input  logic [31:0] local_addr,
  input  logic [15:0] local_port,
  input  logic [31:0] dest_addr,
  input  logic [15:0] dest_port,
  input  logic [15:0] payload_tag,
  input  logic [61:0] now_ns,
  input  logic [19:0] loss_draw,
  input  logic [31:0] jitter_draw,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [62:0] time_ns,
  output logic [31:0] from_addr,
  output logic [15:0] from_port,
  output logic [15:0] out_tag,
  output logic [31:0] seq_number
);
  import ldds_pkg::*;

  localparam int SW = $clog2(NUM_SOCKETS);
  localparam int IW = $clog2(INBOX_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state, state_next;

  logic [19:0] loss_rate;
  logic [31:0] base_lat;
  logic [31:0] max_jit;
  logic [15:0] auto_port;
  logic [31:0] send_seq;

  op_t         op_q;
  logic [3:0]  sock_q;
  logic [31:0] laddr_q;
  logic [15:0] lport_q;
  logic [31:0] daddr_q;
  logic [15:0] dport_q;
  logic [15:0] tag_q;
  logic [61:0] now_q;
  logic [19:0] ldraw_q;
  logic [31:0] extra_q;
  logic [62:0] due_q;
  logic        start;

  sock_pkt_t   spkt [NUM_SOCKETS+1];
  logic [SW-1:0] sown [NUM_SOCKETS+1];
  inbox_pkt_t  ipkt [INBOX_DEPTH+1];
  logic [IW-1:0] ibest [INBOX_DEPTH+1];
  logic [IW-1:0] ifree [INBOX_DEPTH+1];

  sock_pkt_t     sres;
  logic [SW-1:0] sres_own;
  logic          sdone;
  inbox_pkt_t    ires;
  logic [IW-1:0] ires_best;
  logic [IW-1:0] ires_free;
  logic          idone;

  logic        accept;
  logic        commit;
  logic        bind_we;
  logic [15:0] bind_port;
  logic        auto_inc;
  logic        ent_we;
  logic        ent_clr;
  logic        sock_oor;
  logic        dropped;
  logic [2:0]  st_n;
  logic [62:0] time_n;
  logic [31:0] addr_n;
  logic [15:0] port_n;
  logic [15:0] tag_n;
  logic [31:0] seq_n;

  assign in_stall = rst || (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign commit   = (state == S_COMMIT) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      loss_rate <= '0;
      base_lat  <= '0;
      max_jit   <= '0;
      auto_port <= FIRST_FREE_PORT_RST;
      send_seq  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_LOSS:   loss_rate <= cfg_data[19:0];
          REG_LAT:    base_lat  <= cfg_data;
          REG_JITTER: max_jit   <= cfg_data;
          REG_PORT:   auto_port <= cfg_data[15:0];
          default: ;
        endcase
      end else if (commit && auto_inc) begin
        auto_port <= auto_port + 16'd1;
      end
      if (commit && ent_we) begin
        send_seq <= send_seq + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op_t'(op);
      sock_q  <= socket;
      laddr_q <= local_addr;
      lport_q <= local_port;
      daddr_q <= dest_addr;
      dport_q <= dest_port;
      tag_q   <= payload_tag;
      now_q   <= now_ns;
      ldraw_q <= loss_draw;
      extra_q <= (jitter_draw < max_jit) ? jitter_draw : max_jit;
    end
    due_q <= 63'(now_q) + 63'(base_lat) + 63'(extra_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      start <= 1'b0;
      sdone <= 1'b0;
      idone <= 1'b0;
    end else begin
      state <= state_next;
      start <= accept;
      if (accept) begin
        sdone <= 1'b0;
        idone <= 1'b0;
      end else begin
        if (spkt[NUM_SOCKETS].valid) sdone <= 1'b1;
        if (ipkt[INBOX_DEPTH].valid) idone <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (spkt[NUM_SOCKETS].valid) begin
      sres     <= spkt[NUM_SOCKETS];
      sres_own <= sown[NUM_SOCKETS];
    end
    if (ipkt[INBOX_DEPTH].valid) begin
      ires      <= ipkt[INBOX_DEPTH];
      ires_best <= ibest[INBOX_DEPTH];
      ires_free <= ifree[INBOX_DEPTH];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_SCAN;
      S_SCAN:   if (sdone && idone) state_next = S_COMMIT;
      S_COMMIT: if (!out_valid) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // token injection
  always_comb begin
    spkt[0].valid = start;
    spkt[0].addr  = (op_q == OP_BIND) ? laddr_q : daddr_q;
    spkt[0].port  = (op_q == OP_BIND) ? lport_q : dport_q;
    spkt[0].sock  = sock_q;
    spkt[0].found = 1'b0;
    spkt[0].bound = 1'b0;
    sown[0]       = '0;
    ipkt[0].valid      = start;
    ipkt[0].key        = sock_q;
    ipkt[0].found      = 1'b0;
    ipkt[0].due        = '0;
    ipkt[0].seq        = '0;
    ipkt[0].sender     = '0;
    ipkt[0].tag        = '0;
    ipkt[0].free_found = 1'b0;
    ibest[0] = '0;
    ifree[0] = '0;
  end

  for (genvar k = 0; k < NUM_SOCKETS; k++) begin : g_sock
    ldds_sock_cell #(.NUM_SOCKETS(NUM_SOCKETS), .IDX(k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .pin     (spkt[k]),
      .oin     (sown[k]),
      .pout    (spkt[k+1]),
      .oout    (sown[k+1]),
      .we      (commit && bind_we),
      .wr_sock (sock_q),
      .wr_addr (laddr_q),
      .wr_port (bind_port)
    );
  end

  for (genvar k = 0; k < INBOX_DEPTH; k++) begin : g_inbox
    ldds_inbox_cell #(.NUM_SOCKETS(NUM_SOCKETS), .INBOX_DEPTH(INBOX_DEPTH), .IDX(k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .pin       (ipkt[k]),
      .bin       (ibest[k]),
      .fin       (ifree[k]),
      .pout      (ipkt[k+1]),
      .bout      (ibest[k+1]),
      .fout      (ifree[k+1]),
      .we        (commit && ent_we),
      .clr       (commit && ent_clr),
      .wr_idx    (ent_clr ? ires_best : ires_free),
      .wr_owner  (sres_own),
      .wr_due    (due_q),
      .wr_seq    (send_seq),
      .wr_sender ({laddr_q, lport_q}),
      .wr_tag    (tag_q)
    );
  end

  assign sock_oor = (int'(sock_q) >= NUM_SOCKETS);
  assign dropped  = (loss_rate != '0) && (ldraw_q < loss_rate);

  always_comb begin
    bind_we   = 1'b0;
    bind_port = lport_q;
    auto_inc  = 1'b0;
    ent_we    = 1'b0;
    ent_clr   = 1'b0;
    st_n      = ST_OK;
    time_n    = '0;
    addr_n    = '0;
    port_n    = '0;
    tag_n     = '0;
    seq_n     = '0;
    unique case (op_q)
      OP_BIND: begin
        if (sock_oor) begin
          st_n = ST_UNAVAIL;
        end else if (sres.bound) begin
          st_n = ST_BUSY;
        end else if (lport_q == '0) begin
          bind_port = auto_port;
          auto_inc  = 1'b1;
          bind_we   = 1'b1;
        end else if (sres.found) begin
          st_n = ST_BUSY;
        end else begin
          bind_we = 1'b1;
        end
        if (bind_we) begin
          addr_n = laddr_q;
          port_n = bind_port;
        end
      end
      OP_SEND: begin
        if (dropped || !sres.found) begin
          st_n = ST_DROPPED;
        end else if (!ires.free_found) begin
          st_n = ST_FULL;
        end else begin
          ent_we = 1'b1;
          time_n = due_q;
          seq_n  = send_seq;
        end
      end
      OP_TAKE, OP_PEEK: begin
        if (sock_oor) begin
          st_n = ST_UNAVAIL;
        end else if (!ires.found) begin
          st_n = ST_NONE;
        end else if (op_q == OP_PEEK) begin
          time_n = ires.due;
        end else if (ires.due > 63'(now_q)) begin
          st_n = ST_NONE;
        end else begin
          ent_clr = 1'b1;
          time_n  = ires.due;
          addr_n  = ires.sender[47:16];
          port_n  = ires.sender[15:0];
          tag_n   = ires.tag;
          seq_n   = ires.seq;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status     <= st_n;
      time_ns    <= time_n;
      from_addr  <= addr_n;
      from_port  <= port_n;
      out_tag    <= tag_n;
      seq_number <= seq_n;
    end
  end

endmodule

FILE: rtl/core/ldds_checker.sv
`include "lossy_delay_datagram_scheduler_assert.svh"

module ldds_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [62:0] time_ns,
  input logic [31:0] from_addr,
  input logic [15:0] from_port,
  input logic [15:0] out_tag,
  input logic [31:0] seq_number
);
  import ldds_pkg::*;

  logic fields_zero;

  assign fields_zero = (time_ns == '0) && (from_addr == '0) && (from_port == '0) &&
                       (out_tag == '0) && (seq_number == '0);

  `LDDS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `LDDS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `LDDS_ASSERT_NOW(a_fail_zero, out_valid && (status != ST_OK), fields_zero)
  `LDDS_ASSERT_NOW(a_idle_on_result, $rose(out_valid), !in_stall)

endmodule

bind lossy_delay_datagram_scheduler ldds_checker u_ldds_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .time_ns    (time_ns),
  .from_addr  (from_addr),
  .from_port  (from_port),
  .out_tag    (out_tag),
  .seq_number (seq_number)
);
